@@ rtl/core/pdcm_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the pwm duty cycle monitor
package pdcm_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned STAMP_W        = 32;
  localparam int unsigned DUTY_W         = 8;
  localparam int unsigned COUNT_W        = 32;
  // width of one subtractor digit in the serial divider
  localparam int unsigned DIGIT_W        = 8;

  localparam logic [DUTY_W-1:0] FULL_OPEN = 8'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_RISE       = 3'd0,
    MODE_FALL       = 3'd1,
    MODE_POLL       = 3'd2,
    MODE_ENERGIZE   = 3'd3,
    MODE_DEENERGIZE = 3'd4
  } mode_e;

  typedef struct packed {
    logic [DUTY_W-1:0]  open_rate;
    logic [DUTY_W-1:0]  short_rate;
    logic               has_discharge;
    logic               enable_out;
    logic [STAMP_W-1:0] measured_period;
    logic [COUNT_W-1:0] polls_done;
    logic               cancelled;
  } result_t;

endpackage

@@ rtl/core/pdcm_if.sv @@
`timescale 1ns / 1ps
// valid/ready channels for edge events and monitor results
interface pdcm_in_if;
  import pdcm_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [STAMP_W-1:0] time_us;
  logic               cancel_request;

  modport source (output valid, output mode, output time_us, output cancel_request,
                  input ready);
  modport sink   (input valid, input mode, input time_us, input cancel_request,
                  output ready);
endinterface

interface pdcm_out_if;
  import pdcm_pkg::*;

  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  open_rate;
  logic [DUTY_W-1:0]  short_rate;
  logic               has_discharge;
  logic               enable_out;
  logic [STAMP_W-1:0] measured_period;
  logic [COUNT_W-1:0] polls_done;
  logic               cancelled;

  modport source (output valid, output open_rate, output short_rate, output has_discharge,
                  output enable_out, output measured_period, output polls_done,
                  output cancelled, input ready);
  modport sink   (input valid, input open_rate, input short_rate, input has_discharge,
                  input enable_out, input measured_period, input polls_done,
                  input cancelled, output ready);
endinterface

@@ rtl/core/pdcm_div.sv @@
`timescale 1ns / 1ps
// digit-serial scaled duty divider: floor(high * 255 / period), saturated
module pdcm_div #(
  parameter int unsigned TIME_WIDTH = pdcm_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [TIME_WIDTH-1:0]         high_i,
  input  logic [TIME_WIDTH-1:0]         period_i,
  output logic                          done_o,
  output logic [pdcm_pkg::DUTY_W-1:0]   duty_o
);
  import pdcm_pkg::*;

  localparam int unsigned NUM_DIG   = (TIME_WIDTH + 1 + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned REM_W     = NUM_DIG * DIGIT_W;
  localparam int unsigned DIG_CNT_W = $clog2(NUM_DIG);
  localparam int unsigned PASS_W    = 4;

  // pass 0 checks high against period, passes 1..8 divide high*256 by period,
  // the last pass compares the remainder against high to turn *256 into *255
  localparam logic [PASS_W-1:0] PASS_RANGE = 4'd0;
  localparam logic [PASS_W-1:0] PASS_FIX   = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUB,
    ST_EVAL
  } state_e;

  state_e                state_q, state_d;
  logic [PASS_W-1:0]     pass_q, pass_d;
  logic [DIG_CNT_W-1:0]  dig_q, dig_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [REM_W-1:0]      s_q, s_d;
  logic [REM_W-1:0]      b_q, b_d;
  logic [REM_W-1:0]      dif_q, dif_d;
  logic                  borrow_q, borrow_d;
  logic [REM_W-1:0]      hgh_q, hgh_d;
  logic [REM_W-1:0]      per_q, per_d;
  logic [DUTY_W-1:0]     quo_q, quo_d;
  logic                  done_q, done_d;
  logic [DUTY_W-1:0]     duty_q, duty_d;

  logic [DIGIT_W:0]      dig_diff;
  logic [REM_W-1:0]      s_load;
  logic                  ge;

  always_comb begin
    state_d  = state_q;
    pass_d   = pass_q;
    dig_d    = dig_q;
    rem_d    = rem_q;
    s_d      = s_q;
    b_d      = b_q;
    dif_d    = dif_q;
    borrow_d = borrow_q;
    hgh_d    = hgh_q;
    per_d    = per_q;
    quo_d    = quo_q;
    done_d   = 1'b0;
    duty_d   = duty_q;

    dig_diff = {1'b0, s_q[DIGIT_W-1:0]} - {1'b0, b_q[DIGIT_W-1:0]}
               - (DIGIT_W+1)'(borrow_q);
    ge       = ~borrow_q;

    if (pass_q == PASS_RANGE || pass_q == PASS_FIX) begin
      s_load = rem_q;
    end else begin
      s_load = {rem_q[REM_W-2:0], 1'b0};
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          hgh_d   = REM_W'(high_i);
          per_d   = REM_W'(period_i);
          rem_d   = REM_W'(high_i);
          pass_d  = PASS_RANGE;
          quo_d   = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rem_d    = s_load;
        s_d      = s_load;
        b_d      = (pass_q == PASS_FIX) ? hgh_q : per_q;
        borrow_d = 1'b0;
        dig_d    = '0;
        state_d  = ST_SUB;
      end
      ST_SUB: begin
        // low digit first, borrow carried to the next cycle
        s_d      = s_q >> DIGIT_W;
        b_d      = b_q >> DIGIT_W;
        dif_d    = {dig_diff[DIGIT_W-1:0], dif_q[REM_W-1:DIGIT_W]};
        borrow_d = dig_diff[DIGIT_W];
        dig_d    = dig_q + 1'b1;
        if (dig_q == DIG_CNT_W'(NUM_DIG - 1)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        pass_d  = pass_q + 1'b1;
        state_d = ST_LOAD;
        if (pass_q == PASS_RANGE) begin
          if (ge) begin
            duty_d  = FULL_OPEN;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (pass_q == PASS_FIX) begin
          // remainder below high means the 255 scale drops one count
          duty_d  = quo_q - DUTY_W'(!ge);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (ge) begin
            rem_d = dif_q;
          end
          quo_d = {quo_q[DUTY_W-2:0], ge};
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= '0;
      dig_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      dig_q   <= dig_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    s_q      <= s_d;
    b_q      <= b_d;
    dif_q    <= dif_d;
    borrow_q <= borrow_d;
    hgh_q    <= hgh_d;
    per_q    <= per_d;
    quo_q    <= quo_d;
    duty_q   <= duty_d;
  end

  assign done_o = done_q;
  assign duty_o = duty_q;

endmodule

@@ rtl/core/pwm_duty_cycle_monitor_core.sv @@
`timescale 1ns / 1ps
// an accepted event that starts no division is registered straight into the output register;
// a dividing poll runs the divider, whose passes use the 8-bit digit-serial subtractor, and
// then waits in ST_PUT for a free output register; a high time at or above the period ends
// the division after the first pass. one event at a time; a result waiting in the output
// register holds off the next event, which is taken in the cycle the result drains.
// async active-low reset clears times and counter, disables the block, duty to full open
module pwm_duty_cycle_monitor_core #(
  parameter int unsigned TIME_WIDTH = pdcm_pkg::TIME_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pdcm_in_if.sink           in_i,
  pdcm_out_if.source        out_o
);
  import pdcm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUT
  } state_e;

  state_e                 state_q, state_d;
  logic [TIME_WIDTH-1:0]  rise_q, rise_d;
  logic [TIME_WIDTH-1:0]  period_q, period_d;
  logic [TIME_WIDTH-1:0]  high_q, high_d;
  logic [DUTY_W-1:0]      duty_q, duty_d;
  logic                   en_q, en_d;
  logic [COUNT_W-1:0]     polls_q, polls_d;
  result_t                res_q, res_d;
  logic                   out_valid_q, out_valid_d;

  logic [TIME_WIDTH-1:0]  now;
  logic                   out_free;
  logic                   in_ready;
  logic                   div_start;
  logic                   div_done;
  logic [DUTY_W-1:0]      div_duty;
  logic                   cancel_hit;

  function automatic result_t make_res(input logic [DUTY_W-1:0]     duty,
                                       input logic                  en,
                                       input logic [TIME_WIDTH-1:0] period,
                                       input logic [COUNT_W-1:0]    polls,
                                       input logic                  canc);
    result_t r;
    r.open_rate       = duty;
    r.short_rate      = FULL_OPEN - duty;
    r.has_discharge   = (duty != FULL_OPEN);
    r.enable_out      = en;
    r.measured_period = STAMP_W'(period);
    r.polls_done      = polls;
    r.cancelled       = canc;
    return r;
  endfunction

  pdcm_div #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .high_i   (high_q),
    .period_i (period_q),
    .done_o   (div_done),
    .duty_o   (div_duty)
  );

  always_comb begin
    state_d     = state_q;
    rise_d      = rise_q;
    period_d    = period_q;
    high_d      = high_q;
    duty_d      = duty_q;
    en_d        = en_q;
    polls_d     = polls_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    div_start   = 1'b0;
    cancel_hit  = 1'b0;

    now      = TIME_WIDTH'(in_i.time_us);
    out_free = ~out_valid_q | out_o.ready;
    in_ready = (state_q == ST_IDLE) & out_free;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid && in_ready) begin
          case (mode_e'(in_i.mode))
            MODE_RISE: begin
              rise_d = now;
              if (rise_q != '0) begin
                period_d = now - rise_q;
              end
            end
            MODE_FALL: begin
              high_d = now - rise_q;
            end
            MODE_POLL: begin
              if (!en_q) begin
                duty_d = FULL_OPEN;
              end else if (in_i.cancel_request) begin
                en_d       = 1'b0;
                duty_d     = FULL_OPEN;
                cancel_hit = 1'b1;
              end else begin
                polls_d = polls_q + 1'b1;
                if (period_q != '0) begin
                  div_start = 1'b1;
                end
              end
            end
            MODE_ENERGIZE: begin
              en_d = 1'b1;
            end
            MODE_DEENERGIZE: begin
              en_d   = 1'b0;
              duty_d = FULL_OPEN;
            end
            default: begin
            end
          endcase

          if (div_start) begin
            state_d = ST_DIV;
          end else begin
            res_d       = make_res(duty_d, en_d, period_d, polls_d, cancel_hit);
            out_valid_d = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          duty_d  = div_duty;
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          res_d       = make_res(duty_q, en_q, period_q, polls_q, 1'b0);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rise_q      <= '0;
      period_q    <= '0;
      high_q      <= '0;
      duty_q      <= FULL_OPEN;
      en_q        <= 1'b0;
      polls_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rise_q      <= rise_d;
      period_q    <= period_d;
      high_q      <= high_d;
      duty_q      <= duty_d;
      en_q        <= en_d;
      polls_q     <= polls_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.open_rate       = res_q.open_rate;
  assign out_o.short_rate      = res_q.short_rate;
  assign out_o.has_discharge   = res_q.has_discharge;
  assign out_o.enable_out      = res_q.enable_out;
  assign out_o.measured_period = res_q.measured_period;
  assign out_o.polls_done      = res_q.polls_done;
  assign out_o.cancelled       = res_q.cancelled;

endmodule
